[design/u8u16_pkg.sv]
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder package
// Payload types, the decoder result bundle and the fixed constants of the
// UTF-8 and UTF-16 encodings.
// ----------------------------------------------------------------------------
package u8u16_pkg;

   localparam int CountWidth = 16;
   localparam int UnitWidth  = 21;

   localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

   localparam logic [7:0] AsciiMask  = 8'h80;
   localparam logic [7:0] Lead2Mask  = 8'hE0;
   localparam logic [7:0] Lead2Code  = 8'hC0;
   localparam logic [7:0] Lead3Mask  = 8'hF0;
   localparam logic [7:0] Lead3Code  = 8'hE0;
   localparam logic [7:0] Lead4Mask  = 8'hF8;
   localparam logic [7:0] Lead4Code  = 8'hF0;
   localparam logic [1:0] ContTag    = 2'b10;

   localparam logic [UnitWidth-1:0] Min2Byte      = 21'h00080;
   localparam logic [UnitWidth-1:0] Min3Byte      = 21'h00800;
   localparam logic [UnitWidth-1:0] Min4Byte      = 21'h10000;
   localparam logic [UnitWidth-1:0] CodeMax       = 21'h10FFFF;
   localparam logic [UnitWidth-1:0] SurrogateLo   = 21'h0D800;
   localparam logic [UnitWidth-1:0] SurrogateHi   = 21'h0DFFF;
   localparam logic [UnitWidth-1:0] LowSurrBase   = 21'h0DC00;
   localparam logic [UnitWidth-1:0] BmpMax        = 21'h0FFFF;
   localparam logic [UnitWidth-1:0] SuppBase      = 21'h10000;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_payload_type;

   typedef struct packed {
      logic [UnitWidth-1:0]  unit_value;
      logic                  unit_valid;
      logic                  string_done;
      logic                  string_ok;
      logic [CountWidth-1:0] unit_count;
      logic                  last_result;
   } rsp_payload_type;

   typedef struct packed {
      logic [1:0]      count;
      rsp_payload_type first;
      rsp_payload_type second;
   } dec_result_type;

endpackage

[design/u8u16_decode.sv]
// ----------------------------------------------------------------------------
// UTF-8 decode step
// Holds the per-string decode state and turns one byte into zero, one or
// two result beats combinationally.
// ----------------------------------------------------------------------------
module u8u16_decode (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      fire,
   input  u8u16_pkg::req_payload_type item,
   input  logic                      wide_units,
   output u8u16_pkg::dec_result_type result
);
   import u8u16_pkg::*;

   logic [UnitWidth-1:0]  acc_ff, acc_in, acc_v;
   logic [1:0]            exp_ff, exp_in, exp_v;
   logic [1:0]            seq_ff, seq_in, seq_v;
   logic                  err_ff, err_in, err_v;
   logic [CountWidth-1:0] cnt_ff, cnt_in, cnt_v;

   logic [7:0]            b;
   logic                  complete;
   logic                  bad_cp;
   logic [1:0]            nu;
   logic [UnitWidth-1:0]  u0, u1;
   logic [UnitWidth-1:0]  offset;
   logic [CountWidth:0]   sum;
   rsp_payload_type       r0, r1;

   assign b = item.data_byte;

   always_comb begin
      acc_v    = acc_ff;
      exp_v    = exp_ff;
      seq_v    = seq_ff;
      err_v    = err_ff;
      complete = 1'b0;
      bad_cp   = 1'b0;
      nu       = 2'd0;
      u0       = '0;
      u1       = '0;
      offset   = '0;
      if (!err_v) begin
         if (exp_v == 2'd0) begin
            if ((b & AsciiMask) == 8'h00) begin
               acc_v    = {13'd0, b};
               seq_v    = 2'd0;
               complete = 1'b1;
            end else if ((b & Lead2Mask) == Lead2Code) begin
               acc_v = {16'd0, b[4:0]};
               exp_v = 2'd1;
               seq_v = 2'd1;
            end else if ((b & Lead3Mask) == Lead3Code) begin
               acc_v = {17'd0, b[3:0]};
               exp_v = 2'd2;
               seq_v = 2'd2;
            end else if ((b & Lead4Mask) == Lead4Code) begin
               acc_v = {18'd0, b[2:0]};
               exp_v = 2'd3;
               seq_v = 2'd3;
            end else begin
               err_v = 1'b1;
            end
         end else if (b[7:6] != ContTag) begin
            err_v = 1'b1;
         end else begin
            acc_v    = {acc_v[UnitWidth-7:0], b[5:0]};
            exp_v    = exp_v - 2'd1;
            complete = (exp_v == 2'd0);
         end

         if (complete) begin
            bad_cp = (seq_v == 2'd1 && acc_v < Min2Byte) ||
                     (seq_v == 2'd2 && acc_v < Min3Byte) ||
                     (seq_v == 2'd3 && acc_v < Min4Byte) ||
                     (acc_v > CodeMax) ||
                     (acc_v >= SurrogateLo && acc_v <= SurrogateHi);
            if (bad_cp) begin
               err_v = 1'b1;
            end else if (!wide_units && acc_v > BmpMax) begin
               offset = acc_v - SuppBase;
               u0     = SurrogateLo + {11'd0, offset[19:10]};
               u1     = LowSurrBase + {11'd0, offset[9:0]};
               nu     = 2'd2;
            end else begin
               u0 = acc_v;
               nu = 2'd1;
            end
            acc_v = '0;
            seq_v = 2'd0;
         end

         if (err_v) begin
            exp_v = 2'd0;
            seq_v = 2'd0;
            acc_v = '0;
         end
      end

      if (item.final_byte && !err_v && exp_v != 2'd0) begin
         err_v = 1'b1;
      end

      sum   = {1'b0, cnt_ff} + {{(CountWidth-1){1'b0}}, nu};
      cnt_v = (sum > {1'b0, CountMax}) ? CountMax : sum[CountWidth-1:0];
   end

   always_comb begin
      r0 = '0;
      r1 = '0;
      r0.unit_value = (nu != 2'd0) ? u0 : '0;
      r0.unit_valid = (nu != 2'd0);
      r1.unit_value = (nu == 2'd2) ? u1 : '0;
      r1.unit_valid = (nu == 2'd2);
      if (nu == 2'd2) begin
         r1.last_result = 1'b1;
         if (item.final_byte) begin
            r1.string_done = 1'b1;
            r1.string_ok   = !err_v;
            r1.unit_count  = cnt_v;
         end
      end else begin
         r0.last_result = (nu == 2'd1) || item.final_byte;
         if (item.final_byte) begin
            r0.string_done = 1'b1;
            r0.string_ok   = !err_v;
            r0.unit_count  = cnt_v;
         end
      end
      result.first  = r0;
      result.second = r1;
      if (nu == 2'd0) begin
         result.count = item.final_byte ? 2'd1 : 2'd0;
      end else begin
         result.count = nu;
      end
   end

   always_comb begin
      acc_in = acc_ff;
      exp_in = exp_ff;
      seq_in = seq_ff;
      err_in = err_ff;
      cnt_in = cnt_ff;
      if (fire) begin
         if (item.final_byte) begin
            acc_in = '0;
            exp_in = 2'd0;
            seq_in = 2'd0;
            err_in = 1'b0;
            cnt_in = '0;
         end else begin
            acc_in = acc_v;
            exp_in = exp_v;
            seq_in = seq_v;
            err_in = err_v;
            cnt_in = cnt_v;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         exp_ff <= 2'd0;
         seq_ff <= 2'd0;
         err_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         exp_ff <= exp_in;
         seq_ff <= seq_in;
         err_ff <= err_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

[design/utf8_to_utf16_validating_decoder.sv]
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 validating decoder
// Decodes a UTF-8 byte stream into UTF-16 units or whole code points,
// with validation and a per-string ok flag and unit count.
// An accepted input beat is registered, then decoded into the result slots.
// Throughput is one byte per cycle while the output is not stalled; a
// surrogate pair fills both result slots, which stalls the input.
// Reset is synchronous and clears all string state and the mode register.
// ----------------------------------------------------------------------------
module utf8_to_utf16_validating_decoder (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  u8u16_pkg::req_payload_type req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output u8u16_pkg::rsp_payload_type rsp_payload,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic                       csr_data
);
   import u8u16_pkg::*;

   logic            wide_ff, wide_in;
   logic            in_valid_ff, in_valid_in;
   req_payload_type in_data_ff, in_data_in;
   rsp_payload_type slot0_ff, slot0_in;
   rsp_payload_type slot1_ff, slot1_in;
   logic [1:0]      cnt_ff, cnt_in;

   logic            req_accept;
   logic            pop;
   logic            can_load;
   logic            proc_fire;
   dec_result_type  dec;

   assign csr_ready  = 1'b1;
   assign pop        = rsp_valid && !rsp_stall;
   assign can_load   = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && pop);
   assign proc_fire  = in_valid_ff && can_load;
   assign req_stall  = in_valid_ff && !can_load;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (cnt_ff != 2'd0);
   assign rsp_payload = slot0_ff;

   u8u16_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .fire       (proc_fire),
      .item       (in_data_ff),
      .wide_units (wide_ff),
      .result     (dec)
   );

   always_comb begin
      wide_in     = (csr_valid && csr_ready) ? csr_data : wide_ff;
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
         in_data_in  = req_payload;
      end else if (proc_fire) begin
         in_valid_in = 1'b0;
      end
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      cnt_in   = cnt_ff;
      if (proc_fire) begin
         slot0_in = dec.first;
         slot1_in = dec.second;
         cnt_in   = dec.count;
      end else if (pop) begin
         slot0_in = slot1_ff;
         cnt_in   = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_ff     <= 1'b0;
         in_valid_ff <= 1'b0;
         cnt_ff      <= 2'd0;
      end else begin
         wide_ff     <= wide_in;
         in_valid_ff <= in_valid_in;
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
      slot0_ff   <= slot0_in;
      slot1_ff   <= slot1_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      proc_fire && in_data_ff.final_byte |-> dec.count != 2'd0)
      else $error("final byte produced no result beat");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.string_done |-> rsp_payload.last_result)
      else $error("string end beat is not the last beat of its byte");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.unit_valid |-> rsp_payload.string_done)
      else $error("empty result beat outside string end");

   assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("result buffer holds more than two beats");

endmodule

[tb/sv/tb_utf8_to_utf16_validating_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the UTF-8 to UTF-16 validating decoder
// Sends a short table of directed bytes, then random strings that are
// mostly well formed and partly broken, in both unit modes. Idle cycles
// are inserted on both sides. Every result beat is checked against a
// predictor kept inside this bench.
// ----------------------------------------------------------------------------
module tb_utf8_to_utf16_validating_decoder;
   import u8u16_pkg::*;

   localparam logic NarrowUnits = 1'b0;
   localparam logic WideUnits   = 1'b1;

   typedef struct {
      logic [7:0]            data;
      logic                  fin;
      logic                  typed;
      logic [UnitWidth-1:0]  value;
      logic                  valid;
      logic                  ok;
      logic [CountWidth-1:0] count;
   } directed_row_type;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_payload;
   logic            csr_valid;
   logic            csr_ready;
   logic            csr_data;

   logic                  wide_mode  = NarrowUnits;
   logic [UnitWidth-1:0]  code_acc   = '0;
   logic [1:0]            conts_due  = '0;
   logic [1:0]            seq_conts  = '0;
   logic                  string_bad = 1'b0;
   logic [CountWidth-1:0] units_sent = '0;

   rsp_payload_type expected_units[$];
   int failures      = 0;
   int decoded_bytes = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left     = 0;

   directed_row_type directed_rows [25] = '{
      '{8'h00, 1'b1, 1'b1, 21'h00000, 1'b1, 1'b1, 16'd1},
      '{8'h7F, 1'b1, 1'b1, 21'h0007F, 1'b1, 1'b1, 16'd1},
      '{8'h80, 1'b1, 1'b1, 21'h00000, 1'b0, 1'b0, 16'd0},
      '{8'hFF, 1'b1, 1'b1, 21'h00000, 1'b0, 1'b0, 16'd0},
      '{8'hC2, 1'b1, 1'b1, 21'h00000, 1'b0, 1'b0, 16'd0},
      '{8'hC0, 1'b0, 1'b0, 21'h00000, 1'b0, 1'b0, 16'd0},
      '{8'h80, 1'b1, 1'b1, 21'h00000, 1'b0, 1'b0, 16'd0},
      '{8'hED, 1'b0, 1'b0, 21'h00000, 1'b0, 1'b0, 16'd0},
      '{8'hA0, 1'b0, 1'b0, 21'h00000, 1'b0, 1'b0, 16'd0},
      '{8'h80, 1'b1, 1'b1, 21'h00000, 1'b0, 1'b0, 16'd0},
      '{8'hF4, 1'b0, 1'b0, 21'h00000, 1'b0, 1'b0, 16'd0},
      '{8'h90, 1'b0, 1'b0, 21'h00000, 1'b0, 1'b0, 16'd0},
      '{8'h80, 1'b0, 1'b0, 21'h00000, 1'b0, 1'b0, 16'd0},
      '{8'h80, 1'b1, 1'b1, 21'h00000, 1'b0, 1'b0, 16'd0},
      '{8'h41, 1'b0, 1'b0, 21'h00000, 1'b0, 1'b0, 16'd0},
      '{8'hC3, 1'b0, 1'b0, 21'h00000, 1'b0, 1'b0, 16'd0},
      '{8'hC3, 1'b1, 1'b1, 21'h00000, 1'b0, 1'b0, 16'd1},
      '{8'hF0, 1'b0, 1'b0, 21'h00000, 1'b0, 1'b0, 16'd0},
      '{8'h9F, 1'b0, 1'b0, 21'h00000, 1'b0, 1'b0, 16'd0},
      '{8'h98, 1'b0, 1'b0, 21'h00000, 1'b0, 1'b0, 16'd0},
      '{8'h80, 1'b0, 1'b0, 21'h00000, 1'b0, 1'b0, 16'd0},
      '{8'hF4, 1'b0, 1'b0, 21'h00000, 1'b0, 1'b0, 16'd0},
      '{8'h8F, 1'b0, 1'b0, 21'h00000, 1'b0, 1'b0, 16'd0},
      '{8'hBF, 1'b0, 1'b0, 21'h00000, 1'b0, 1'b0, 16'd0},
      '{8'hBF, 1'b1, 1'b0, 21'h00000, 1'b0, 1'b0, 16'd0}
   };

   utf8_to_utf16_validating_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic append_beat(input rsp_payload_type beat);
      expected_units.insert(expected_units.size(), beat);
   endtask

   task automatic append_byte(ref logic [7:0] q[$], input logic [7:0] value);
      q.insert(q.size(), value);
   endtask

   task automatic predict_byte(input logic [7:0] b, input logic fin);
      rsp_payload_type      beats [2];
      logic [UnitWidth-1:0] units [2];
      logic [UnitWidth-1:0] cp;
      logic [UnitWidth-1:0] offset;
      int                   nu;
      int                   n;
      logic                 complete;
      nu = 0;
      complete = 1'b0;
      if (!string_bad) begin
         decoded_bytes++;
         if (conts_due == 2'd0) begin
            if (b[7] == 1'b0) begin
               code_acc = {13'd0, b};
               seq_conts = 2'd0;
               complete = 1'b1;
            end else if (b[7:5] == 3'b110) begin
               code_acc = {16'd0, b[4:0]};
               conts_due = 2'd1;
               seq_conts = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
               code_acc = {17'd0, b[3:0]};
               conts_due = 2'd2;
               seq_conts = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
               code_acc = {18'd0, b[2:0]};
               conts_due = 2'd3;
               seq_conts = 2'd3;
            end else begin
               string_bad = 1'b1;
            end
         end else if (b[7:6] != 2'b10) begin
            string_bad = 1'b1;
         end else begin
            code_acc = {code_acc[14:0], b[5:0]};
            conts_due = conts_due - 2'd1;
            complete = (conts_due == 2'd0);
         end
         if (complete) begin
            cp = code_acc;
            if ((seq_conts == 2'd1 && cp < Min2Byte) ||
                (seq_conts == 2'd2 && cp < Min3Byte) ||
                (seq_conts == 2'd3 && cp < Min4Byte) ||
                cp > CodeMax || (cp >= SurrogateLo && cp <= SurrogateHi)) begin
               string_bad = 1'b1;
            end else if (wide_mode == NarrowUnits && cp > BmpMax) begin
               offset = cp - SuppBase;
               units[0] = SurrogateLo + {11'd0, offset[19:10]};
               units[1] = LowSurrBase + {11'd0, offset[9:0]};
               nu = 2;
            end else begin
               units[0] = cp;
               nu = 1;
            end
            code_acc = '0;
            seq_conts = '0;
         end
         if (string_bad) begin
            conts_due = '0;
            seq_conts = '0;
            code_acc = '0;
         end
      end
      if (fin && !string_bad && conts_due != 2'd0) string_bad = 1'b1;
      for (n = 0; n < nu; n++) begin
         if (units_sent != CountMax) units_sent++;
         beats[n] = '0;
         beats[n].unit_value = units[n];
         beats[n].unit_valid = 1'b1;
      end
      if (fin) begin
         if (n == 0) begin
            beats[0] = '0;
            n = 1;
         end
         beats[n-1].string_done = 1'b1;
         beats[n-1].string_ok = !string_bad;
         beats[n-1].unit_count = units_sent;
         code_acc = '0;
         conts_due = '0;
         seq_conts = '0;
         string_bad = 1'b0;
         units_sent = '0;
      end
      if (n > 0) beats[n-1].last_result = 1'b1;
      for (int i = 0; i < n; i++) append_beat(beats[i]);
   endtask

   task automatic send_byte(input logic [7:0] b, input logic fin);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_payload.data_byte = b;
      req_payload.final_byte = fin;
      do @(posedge clock); while (req_stall);
      predict_byte(b, fin);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_units.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_mode(input logic mode);
      drain();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data = mode;
      do @(posedge clock); while (!csr_ready);
      wide_mode = mode;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic int utf8_length(input logic [UnitWidth-1:0] cp);
      if (cp < Min2Byte) return 1;
      if (cp < Min3Byte) return 2;
      if (cp < Min4Byte) return 3;
      return 4;
   endfunction

   task automatic put_code(ref logic [7:0] q[$], input logic [UnitWidth-1:0] cp,
                           input int len);
      case (len)
         1: append_byte(q, cp[7:0]);
         2: begin
            append_byte(q, {3'b110, cp[10:6]});
            append_byte(q, {2'b10, cp[5:0]});
         end
         3: begin
            append_byte(q, {4'b1110, cp[15:12]});
            append_byte(q, {2'b10, cp[11:6]});
            append_byte(q, {2'b10, cp[5:0]});
         end
         default: begin
            append_byte(q, {5'b11110, cp[20:18]});
            append_byte(q, {2'b10, cp[17:12]});
            append_byte(q, {2'b10, cp[11:6]});
            append_byte(q, {2'b10, cp[5:0]});
         end
      endcase
   endtask

   task automatic add_char(ref logic [7:0] q[$]);
      logic [UnitWidth-1:0] boundary_points [10] = '{
         21'h00000, 21'h0007F, 21'h00080, 21'h007FF, 21'h00800,
         21'h0D7FF, 21'h0E000, 21'h0FFFF, 21'h10000, 21'h10FFFF
      };
      logic [7:0]           part[$];
      logic [UnitWidth-1:0] cp;
      int                   pick;
      int                   len;
      pick = $urandom_range(99);
      if (pick < 30) begin
         cp = 21'($urandom_range(8'h7F));
      end else if (pick < 50) begin
         cp = 21'($urandom_range(16'h7FF, 16'h80));
      end else if (pick < 68) begin
         cp = 21'($urandom_range(16'hFFFF, 16'h800));
         if (cp >= SurrogateLo && cp <= SurrogateHi) cp[13] = 1'b1;
      end else if (pick < 84) begin
         cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
      end else if (pick < 90) begin
         cp = boundary_points[$urandom_range(9)];
      end else begin
         case ($urandom_range(5))
            0: append_byte(q, 8'($urandom_range(255)));
            1: append_byte(q, {2'b10, 6'($urandom)});
            2: begin
               len = $urandom_range(4, 2);
               cp = (len == 2) ? 21'($urandom_range(8'h7F)) :
                    (len == 3) ? 21'($urandom_range(16'h7FF)) :
                                 21'($urandom_range(16'hFFFF));
               put_code(q, cp, len);
            end
            3: put_code(q, 21'($urandom_range(16'hDFFF, 16'hD800)), 3);
            4: put_code(q, 21'($urandom_range(21'h1FFFFF, 21'h110000)), 4);
            default: begin
               cp = 21'($urandom_range(21'h10FFFF, 21'h80));
               put_code(part, cp, utf8_length(cp));
               void'(part.pop_back());
               foreach (part[i]) append_byte(q, part[i]);
            end
         endcase
         return;
      end
      put_code(q, cp, utf8_length(cp));
   endtask

   task automatic send_random_strings(input int byte_goal);
      logic [7:0] text[$];
      int         chars;
      byte_goal += decoded_bytes;
      while (decoded_bytes < byte_goal) begin
         text.delete();
         chars = $urandom_range(6, 1);
         repeat (chars) add_char(text);
         foreach (text[i]) send_byte(text[i], i == text.size() - 1);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_units.size() == 0) begin
            $error("result beat with no expected beat: unit_value 0x%0h",
                   rsp_payload.unit_value);
            failures++;
         end else begin
            want = expected_units.pop_front();
            check_field("unit_value", 32'(want.unit_value), 32'(rsp_payload.unit_value));
            check_field("unit_valid", 32'(want.unit_valid), 32'(rsp_payload.unit_valid));
            check_field("string_done", 32'(want.string_done),
                        32'(rsp_payload.string_done));
            check_field("string_ok", 32'(want.string_ok), 32'(rsp_payload.string_ok));
            check_field("unit_count", 32'(want.unit_count), 32'(rsp_payload.unit_count));
            check_field("last_result", 32'(want.last_result),
                        32'(rsp_payload.last_result));
         end
      end
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            rsp_stall = ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   initial begin
      rsp_payload_type typed_beat;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_valid = 1'b0;
      csr_data = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 28;
      recv_idle_pct = 59;
      foreach (directed_rows[i]) begin
         send_byte(directed_rows[i].data, directed_rows[i].fin);
         if (directed_rows[i].typed) begin
            void'(expected_units.pop_back());
            typed_beat = '0;
            typed_beat.unit_value = directed_rows[i].value;
            typed_beat.unit_valid = directed_rows[i].valid;
            typed_beat.string_done = 1'b1;
            typed_beat.string_ok = directed_rows[i].ok;
            typed_beat.unit_count = directed_rows[i].count;
            typed_beat.last_result = 1'b1;
            append_beat(typed_beat);
         end
      end

      write_mode(WideUnits);
      send_random_strings(165);
      drain();
      send_random_strings(165);

      write_mode(NarrowUnits);
      send_idle_pct = 59;
      recv_idle_pct = 28;
      hold_left = 300;
      send_random_strings(330);

      write_mode(WideUnits);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random_strings(330);

      write_mode(NarrowUnits);
      send_random_strings(40);
      drain();

      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[files.f]
design/u8u16_pkg.sv
design/u8u16_decode.sv
design/utf8_to_utf16_validating_decoder.sv
tb/sv/tb_utf8_to_utf16_validating_decoder.sv
